// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dsvq_pkg.sv =====
`default_nettype none

package dsvq_pkg;

  localparam int CHAR_W       = 8;
  localparam int MAX_CELL_DEF = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CHAR_W-1:0] QUOTE_CHAR   = 8'h22;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] DELIM_RESET  = 8'd44;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_ALL = 1'b1;

  // Source of the character loaded into the output register
  typedef enum logic [1:0] {
    SEL_QUOTE,
    SEL_DATA,
    SEL_SEP
  } emit_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      rd;
    logic      emit;
    emit_sel_t sel;
    logic      idx_inc;
    logic      clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic closes;
    logic quoted;
    logic len_zero;
    logic idx_last;
    logic is_quote;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/dsvq_ram.sv =====
`default_nettype none

module dsvq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port that holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dsvq_ctrl.sv =====
`default_nettype none

module dsvq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dsvq_pkg::stat_t stat,
  output dsvq_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_OPEN,
    S_READ,
    S_CHAR,
    S_DUP,
    S_CLOSE,
    S_SEP
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.sel     = dsvq_pkg::SEL_QUOTE;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.closes) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.quoted) begin
          state_next = S_OPEN;
        end else if (stat.len_zero) begin
          state_next = S_SEP;
        end else begin
          state_next = S_READ;
        end
      end
      S_OPEN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = dsvq_pkg::SEL_QUOTE;
          state_next = stat.len_zero ? S_CLOSE : S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHAR;
      end
      S_CHAR: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.quoted && stat.is_quote) begin
            // double an embedded quote
            cmd.sel    = dsvq_pkg::SEL_QUOTE;
            state_next = S_DUP;
          end else begin
            cmd.sel     = dsvq_pkg::SEL_DATA;
            cmd.idx_inc = 1'b1;
            if (!stat.idx_last) begin
              state_next = S_READ;
            end else begin
              state_next = stat.quoted ? S_CLOSE : S_SEP;
            end
          end
        end
      end
      S_DUP: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = dsvq_pkg::SEL_DATA;
          cmd.idx_inc = 1'b1;
          state_next  = stat.idx_last ? S_CLOSE : S_READ;
        end
      end
      S_CLOSE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = dsvq_pkg::SEL_QUOTE;
          state_next = S_SEP;
        end
      end
      S_SEP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = dsvq_pkg::SEL_SEP;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/dsvq_dp.sv =====
`default_nettype none

module dsvq_dp #(
  parameter int MAX_CELL = dsvq_pkg::MAX_CELL_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [dsvq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dsvq_pkg::CHAR_W-1:0]         cfg_data,
  input  wire logic [dsvq_pkg::CHAR_W-1:0]         char_in,
  input  wire logic                                char_valid,
  input  wire logic                                cell_end,
  input  wire logic                                row_end,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic      [dsvq_pkg::CHAR_W-1:0]         char_out,
  output logic                                     last_of_run,
  output logic                                     cell_overflow,
  input  wire dsvq_pkg::cmd_t                      cmd,
  output dsvq_pkg::stat_t                          stat
);

  localparam int LEN_W = $clog2(MAX_CELL + 1);
  localparam int IDX_W = (MAX_CELL > 1) ? $clog2(MAX_CELL) : 1;

  logic [dsvq_pkg::CHAR_W-1:0] delimiter;
  logic                        quote_all;
  logic [LEN_W-1:0]            len;
  logic                        needs_quoting;
  logic                        overflowed;
  logic                        quoted;
  logic                        row_end_held;
  logic [IDX_W-1:0]            idx;
  logic [dsvq_pkg::CHAR_W-1:0] rd_data;
  logic                        room;
  logic                        wr;
  logic                        special;
  logic [dsvq_pkg::CHAR_W-1:0] emit_char;

  assign room    = len < LEN_W'(MAX_CELL);
  assign wr      = cmd.accept && char_valid && room;
  assign special = (char_in == delimiter) || (char_in == dsvq_pkg::QUOTE_CHAR) ||
                   (char_in == dsvq_pkg::NEWLINE_CHAR);

  // Cell buffer
  dsvq_ram #(
    .WIDTH  (dsvq_pkg::CHAR_W),
    .DEPTH  (MAX_CELL),
    .ADDR_W (IDX_W)
  ) u_buf (
    .clk   (clk),
    .we    (wr),
    .waddr (len[IDX_W-1:0]),
    .wdata (char_in),
    .re    (cmd.rd),
    .raddr (idx),
    .rdata (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= dsvq_pkg::DELIM_RESET;
      quote_all <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsvq_pkg::REG_DELIMITER: delimiter <= cfg_data;
        dsvq_pkg::REG_QUOTE_ALL: quote_all <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Cell bookkeeping: append, flag drops, advance the read index, clear after the separator
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      len           <= '0;
      needs_quoting <= 1'b0;
      overflowed    <= 1'b0;
      idx           <= '0;
    end else begin
      if (wr) begin
        len <= len + LEN_W'(1);
        if (special) begin
          needs_quoting <= 1'b1;
        end
      end
      if (cmd.accept && char_valid && !room) begin
        overflowed <= 1'b1;
      end
      if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // Capture quoting decision and row end with each accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quoted       <= quote_all || needs_quoting || (wr && special);
      row_end_held <= row_end;
    end
  end

  always_comb begin
    case (cmd.sel)
      dsvq_pkg::SEL_QUOTE: emit_char = dsvq_pkg::QUOTE_CHAR;
      dsvq_pkg::SEL_DATA:  emit_char = rd_data;
      dsvq_pkg::SEL_SEP:   emit_char = row_end_held ? dsvq_pkg::NEWLINE_CHAR : delimiter;
      default:             emit_char = dsvq_pkg::QUOTE_CHAR;
    endcase
  end

  // Output register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_out      <= emit_char;
      last_of_run   <= cmd.sel == dsvq_pkg::SEL_SEP;
      cell_overflow <= overflowed;
    end
  end

  assign stat.closes   = cell_end || row_end;
  assign stat.quoted   = quoted;
  assign stat.len_zero = len == '0;
  assign stat.idx_last = (LEN_W'(idx) + LEN_W'(1)) == len;
  assign stat.is_quote = rd_data == dsvq_pkg::QUOTE_CHAR;
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== design/dsv_row_field_quoter_unit.sv =====
// Row encoder for delimiter-separated text with standard quoting.
// Input channel (in_valid/in_ready): one cell character per transfer, with
// char_valid, cell_end and row_end marks. A transfer without an end mark is
// buffered and the block is ready again the next cycle.
// A closing transfer starts the replay of the cell: a setup step, an opening
// quote if the cell is quoted, a read and an emit per buffered character (an
// embedded quote in a quoted cell is emitted twice), a closing quote if quoted,
// and the delimiter or newline. Each character is read from the registered cell
// buffer before it is emitted. No new input is taken during the replay.
// Output channel (out_valid/out_ready): one encoded character per transfer;
// last_of_run marks the separator that ends the cell's run, cell_overflow
// marks every character of a cell whose excess characters were dropped.
// A stalled receiver holds the output register and pauses the replay.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets the
// delimiter, index 1 the quote-all flag; write only while idle.
// Reset (synchronous, rst) empties the cell, restores the delimiter to a
// comma, clears quote-all and drops any pending output.
`default_nettype none

module dsv_row_field_quoter_unit #(
  parameter int MAX_CELL = dsvq_pkg::MAX_CELL_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dsvq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsvq_pkg::CHAR_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dsvq_pkg::CHAR_W-1:0]    char_in,
  input  wire logic                           char_valid,
  input  wire logic                           cell_end,
  input  wire logic                           row_end,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dsvq_pkg::CHAR_W-1:0]    char_out,
  output logic                                last_of_run,
  output logic                                cell_overflow
);

  dsvq_pkg::cmd_t  cmd;
  dsvq_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  dsvq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsvq_dp #(
    .MAX_CELL (MAX_CELL)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .char_in       (char_in),
    .char_valid    (char_valid),
    .cell_end      (cell_end),
    .row_end       (row_end),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .char_out      (char_out),
    .last_of_run   (last_of_run),
    .cell_overflow (cell_overflow),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire

// ===== design/dsvq_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module dsvq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        cell_end,
  input wire logic                        row_end,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [dsvq_pkg::CHAR_W-1:0] char_out
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // A stalled result holds its character
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(char_out), "stalled output changed")

  // A transfer that closes no cell leaves the block ready
  `ASSERT_CLK(a_open_ready, clk, rst, in_xfer && !cell_end && !row_end |=> in_ready, "not ready after buffering")

  // A closing transfer starts a replay that blocks input
  `ASSERT_CLK(a_close_busy, clk, rst, in_xfer && (cell_end || row_end) |=> !in_ready, "input taken during replay")

  // Reset drops any pending output
  `ASSERT_CLK_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind dsv_row_field_quoter_unit dsvq_checker u_dsvq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cell_end  (cell_end),
  .row_end   (row_end),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .char_out  (char_out)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CW         = dsvq_pkg::CHAR_W;
  localparam int IW         = dsvq_pkg::CFG_IDX_W;
  localparam int CELL_CAP   = dsvq_pkg::MAX_CELL_DEF;
  localparam int SETTLE_CYC = 40;
  localparam int LONG_HOLD  = 300;

  typedef struct {
    logic [CW-1:0] ch;
    logic          valid;
    logic          ends_cell;
    logic          ends_row;
  } cell_item_t;

  typedef struct {
    logic [CW-1:0] ch;
    logic          last;
    logic          ovf;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = dsvq_pkg::REG_DELIMITER;
  logic [CW-1:0] cfg_data = '0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [CW-1:0] char_in = '0;
  logic          char_valid = 1'b0;
  logic          cell_end = 1'b0;
  logic          row_end = 1'b0;

  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CW-1:0] char_out;
  logic          last_of_run;
  logic          cell_overflow;

  dsv_row_field_quoter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_in      (char_in),
    .char_valid   (char_valid),
    .cell_end     (cell_end),
    .row_end      (row_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_out     (char_out),
    .last_of_run  (last_of_run),
    .cell_overflow(cell_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and cell state of the encoder
  logic [CW-1:0] delim_shadow = dsvq_pkg::DELIM_RESET;
  logic          qall_shadow = 1'b0;
  logic [CW-1:0] cell_chars [CELL_CAP];
  int            cell_len = 0;
  logic          cell_needs_quote = 1'b0;
  logic          cell_dropped = 1'b0;

  cell_item_t pending_items[$];
  enc_char_t  expected_chars[$];

  int   n_pushed = 0;
  int   n_accepted = 0;
  int   n_fail = 0;
  int   stim_count = 0;
  int   rx_hold_req = 0;
  logic no_idle = 1'b0;

  function automatic void push_char(logic [CW-1:0] c, logic last);
    enc_char_t e;
    e.ch   = c;
    e.last = last;
    e.ovf  = cell_dropped;
    expected_chars.push_back(e);
  endfunction

  // Buffer one character and, on a cell end, queue the encoded cell
  function automatic void encode_item(cell_item_t it);
    logic quoted;
    if (it.valid) begin
      if (cell_len < CELL_CAP) begin
        cell_chars[cell_len] = it.ch;
        cell_len++;
        if (it.ch == delim_shadow || it.ch == dsvq_pkg::QUOTE_CHAR ||
            it.ch == dsvq_pkg::NEWLINE_CHAR)
          cell_needs_quote = 1'b1;
      end else begin
        cell_dropped = 1'b1;
      end
    end
    if (!(it.ends_cell || it.ends_row)) return;
    quoted = qall_shadow || cell_needs_quote;
    if (quoted) push_char(dsvq_pkg::QUOTE_CHAR, 1'b0);
    for (int i = 0; i < cell_len; i++) begin
      if (quoted && cell_chars[i] == dsvq_pkg::QUOTE_CHAR)
        push_char(dsvq_pkg::QUOTE_CHAR, 1'b0);
      push_char(cell_chars[i], 1'b0);
    end
    if (quoted) push_char(dsvq_pkg::QUOTE_CHAR, 1'b0);
    push_char(it.ends_row ? dsvq_pkg::NEWLINE_CHAR : delim_shadow, 1'b1);
    cell_len         = 0;
    cell_needs_quote = 1'b0;
    cell_dropped     = 1'b0;
  endfunction

  // Input driver: one item per transfer, random gap after each item unless no_idle is set
  int tx_wait = 0;
  always @(posedge clk) begin : tx_side
    cell_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it.ch        = char_in;
        it.valid     = char_valid;
        it.ends_cell = cell_end;
        it.ends_row  = row_end;
        encode_item(it);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          in_valid <= 1'b0;
          tx_wait--;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          char_in    <= it.ch;
          char_valid <= it.valid;
          cell_end   <= it.ends_cell;
          row_end    <= it.ends_row;
          in_valid   <= 1'b1;
          tx_wait = no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each transfer, stall at random, hold off on request
  int rx_wait = 0;
  int rx_hold_done = 0;
  always @(posedge clk) begin : rx_side
    enc_char_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output: char_out=%02h", char_out);
          n_fail++;
        end else begin
          e = expected_chars.pop_front();
          if (char_out !== e.ch) begin
            $error("char_out: expected %02h, actual %02h", e.ch, char_out);
            n_fail++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run: expected %0b, actual %0b", e.last, last_of_run);
            n_fail++;
          end
          if (cell_overflow !== e.ovf) begin
            $error("cell_overflow: expected %0b, actual %0b", e.ovf, cell_overflow);
            n_fail++;
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold_done != rx_hold_req) begin
        rx_hold_done = rx_hold_req;
        rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_item(logic [CW-1:0] c, logic v, logic ce, logic re);
    cell_item_t it;
    it.ch        = c;
    it.valid     = v;
    it.ends_cell = ce;
    it.ends_row  = re;
    pending_items.push_back(it);
    n_pushed++;
    if (v || ce || re) stim_count++;
  endtask

  // Hold until every item is taken and every result has arrived
  task automatic wait_idle();
    do @(posedge clk);
    while (n_accepted != n_pushed || expected_chars.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == dsvq_pkg::REG_DELIMITER) delim_shadow = val;
    else qall_shadow = val[0];
    cfg_valid <= 1'b0;
  endtask

  // Mostly plain characters, with a fair share of the ones that force quotes
  function automatic logic [CW-1:0] pick_char();
    case ($urandom_range(0, 7))
      0:       return delim_shadow;
      1:       return dsvq_pkg::QUOTE_CHAR;
      2:       return dsvq_pkg::NEWLINE_CHAR;
      default: return CW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_cell();
    int   len;
    int   r;
    logic with_char;
    logic ends_row;
    r = $urandom_range(0, 9);
    if (r < 7) len = $urandom_range(0, 5);
    else if (r < 9) len = $urandom_range(6, CELL_CAP);
    else len = $urandom_range(CELL_CAP + 1, CELL_CAP + 4);
    with_char = (len > 0) && $urandom_range(0, 1);
    ends_row  = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0)
        add_item(CW'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      if (with_char && k == len - 1)
        add_item(pick_char(), 1'b1, ends_row ? 1'($urandom_range(0, 1)) : 1'b1, ends_row);
      else
        add_item(pick_char(), 1'b1, 1'b0, 1'b0);
    end
    if (!with_char)
      add_item(CW'($urandom_range(0, 255)), 1'b0,
               ends_row ? 1'($urandom_range(0, 1)) : 1'b1, ends_row);
  endtask

  initial begin : stimulus
    int target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: plain, empty, idle item, quote, delimiter, newline, extremes
    add_item("a", 1'b1, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b0, 1'b0);
    add_item(dsvq_pkg::QUOTE_CHAR, 1'b1, 1'b1, 1'b0);
    add_item(dsvq_pkg::DELIM_RESET, 1'b1, 1'b0, 1'b1);
    add_item(dsvq_pkg::NEWLINE_CHAR, 1'b1, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b1, 1'b1);
    // Overfill one cell; the closing character is dropped too
    for (int k = 0; k < CELL_CAP + 1; k++)
      add_item(CW'(8'h41 + k), 1'b1, 1'b0, 1'b0);
    add_item(dsvq_pkg::QUOTE_CHAR, 1'b1, 1'b1, 1'b0);
    // Delimiter changed partway through a cell
    add_item("x", 1'b1, 1'b0, 1'b0);
    add_item("|", 1'b1, 1'b0, 1'b0);
    wait_idle();
    write_reg(dsvq_pkg::REG_DELIMITER, "|");
    add_item("y", 1'b1, 1'b1, 1'b0);
    wait_idle();
    write_reg(dsvq_pkg::REG_QUOTE_ALL, 8'd1);
    add_item(8'h00, 1'b0, 1'b1, 1'b0);
    add_item("|", 1'b1, 1'b1, 1'b1);

    // Random phases over several register settings
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(dsvq_pkg::REG_DELIMITER, 8'h00);
          write_reg(dsvq_pkg::REG_QUOTE_ALL, 8'd1);
        end
        1: begin
          write_reg(dsvq_pkg::REG_DELIMITER, 8'hFF);
          write_reg(dsvq_pkg::REG_QUOTE_ALL, 8'd0);
          rx_hold_req++;
        end
        2: begin
          write_reg(dsvq_pkg::REG_DELIMITER, CW'($urandom_range(0, 255)));
          write_reg(dsvq_pkg::REG_QUOTE_ALL, 8'd0);
        end
        default: begin
          write_reg(dsvq_pkg::REG_DELIMITER, dsvq_pkg::DELIM_RESET);
          write_reg(dsvq_pkg::REG_QUOTE_ALL, 8'd1);
        end
      endcase
      no_idle = (ph == 2);
      target = stim_count + 30;
      while (stim_count < target) add_random_cell();
    end

    wait_idle();
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== dsv_row_field_quoter_unit.f =====
+incdir+design
design/dsvq_pkg.sv
design/dsvq_ram.sv
design/dsvq_ctrl.sv
design/dsvq_dp.sv
design/dsv_row_field_quoter_unit.sv
design/dsvq_checker.sv
verif/testbench.sv
